### design/cpsd_pkg.sv
// Shared types, codes and constants of the count-prefixed signed decimal decoder.
// Used by the channel interfaces, cpsd_core and the top level; depends on nothing.
package cpsd_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 10;

    localparam int SYMBOL_W = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int MAG_W    = 32;
    localparam int START_W  = 4;
    localparam int POS_W    = 5;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOF  = 2'd2;

    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_W-1:0] CH_ONE   = 8'h31;
    localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_LEAD_ZERO = 3'd2,
        ST_NONDIGIT  = 3'd3,
        ST_END_DATA  = 3'd4,
        ST_END_FILE  = 3'd5
    } t_status;

    typedef struct packed {
        t_status            status;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
    } t_result;

    // character at position pos of the all-ones value written with ndig digits,
    // zero padded on the left, low-order digits kept; evaluated at elaboration only
    function automatic logic [SYMBOL_W-1:0] max_str_char(int vbits, int ndig, int pos);
        logic [63:0] v;
        logic [SYMBOL_W-1:0] c;
        v = (vbits >= 64) ? '1 : ((64'd1 << vbits) - 64'd1);
        c = CH_ZERO;
        for (int i = ndig - 1; i >= 0; i--) begin
            if (i == pos) begin
                c = CH_ZERO + SYMBOL_W'(v % 64'd10);
            end
            v = v / 64'd10;
        end
        return c;
    endfunction

endpackage

### design/cpsd_in_if.sv
// Input channel of the decoder: one stream byte or end marker per beat.
// Depends on cpsd_pkg for field widths.
interface cpsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [cpsd_pkg::SYMBOL_W-1:0] symbol;
    logic [cpsd_pkg::KIND_W-1:0]   kind;

    modport source (output valid, output symbol, output kind, input ready);
    modport sink   (input valid, input symbol, input kind, output ready);
endinterface

### design/cpsd_out_if.sv
// Result channel of the decoder: one status beat per finished decode.
// Depends on cpsd_pkg for the status type and widths.
interface cpsd_out_if;
    logic                       valid;
    logic                       ready;
    cpsd_pkg::t_status          status;
    logic                       negative;
    logic [cpsd_pkg::MAG_W-1:0] magnitude;

    modport source (output valid, output status, output negative, output magnitude, input ready);
    modport sink   (input valid, input status, input negative, input magnitude, output ready);
endinterface

### design/cpsd_core.sv
// Decode state and per-byte step logic of the count-prefixed decimal decoder.
// Depends on cpsd_pkg; instantiated by count_prefixed_signed_decimal_decoder.
module cpsd_core #(
    parameter int VALUE_BITS = cpsd_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = cpsd_pkg::DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [cpsd_pkg::SYMBOL_W-1:0] i_symbol,
    input  logic [cpsd_pkg::KIND_W-1:0]   i_kind,
    input  logic [cpsd_pkg::START_W-1:0]  i_start_count,
    output logic                          o_emit,
    output cpsd_pkg::t_result             o_result
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int EXT_W = (VALUE_BITS > cpsd_pkg::MAG_W) ? VALUE_BITS : cpsd_pkg::MAG_W;
    localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;
    localparam logic [VALUE_BITS-1:0] VAL_ONE = VALUE_BITS'(1);
    localparam logic [VALUE_BITS-1:0] VAL_MAXD = VALUE_BITS'(MAX_DIGITS);
    localparam logic [cpsd_pkg::POS_W-1:0] POS_MAXD = cpsd_pkg::POS_W'(MAX_DIGITS);
    localparam logic [cpsd_pkg::POS_W-1:0] POS_SAT = '1;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_FINAL  = 2'd2,
        PH_NESTED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } t_cmp;

    t_phase                        r_phase, n_phase;
    logic [VALUE_BITS-1:0]         r_remaining, n_remaining;
    logic [VALUE_BITS-1:0]         r_group_len, n_group_len;
    logic [VALUE_BITS-1:0]         r_acc, n_acc;
    t_cmp                          r_cmp, n_cmp;
    logic                          r_bad, n_bad;
    logic                          r_sign, n_sign;
    logic [cpsd_pkg::POS_W-1:0]    r_pos, n_pos;

    logic [cpsd_pkg::SYMBOL_W-1:0] w_max_str [MAX_DIGITS];

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_max_str
        assign w_max_str[g] = cpsd_pkg::max_str_char(VALUE_BITS, MAX_DIGITS, g);
    end

    logic                          w_first;
    logic [VALUE_BITS-1:0]         w_glen;
    logic [VALUE_BITS-1:0]         w_acc_b, w_acc_f;
    t_cmp                          w_cmp_b, w_cmp_f;
    logic                          w_bad_f;
    logic [cpsd_pkg::POS_W-1:0]    w_pos_b, w_pos_f;
    logic [cpsd_pkg::SYMBOL_W-1:0] w_ref_char;
    logic                          w_is_digit;
    logic [VALUE_BITS-1:0]         w_rem_f;
    logic                          w_over;
    logic [EXT_W-1:0]              w_acc_ext;
    logic [EXT_W-1:0]              w_max_ext;

    assign w_first = (r_phase == PH_START) || (r_phase == PH_NESTED);

    always_comb begin
        if (r_phase == PH_START) begin
            w_glen = (i_start_count == '0) ? VAL_ONE : VALUE_BITS'(i_start_count);
        end else begin
            w_glen = r_group_len;
        end
    end

    // a digit opening a group starts from cleared group state
    assign w_acc_b = w_first ? '0 : r_acc;
    assign w_cmp_b = w_first ? CMP_EQ : r_cmp;
    assign w_pos_b = w_first ? '0 : r_pos;

    assign w_ref_char = (w_pos_b < POS_MAXD) ? w_max_str[w_pos_b[IDX_W-1:0]] : cpsd_pkg::CH_ZERO;
    assign w_is_digit = (i_symbol >= cpsd_pkg::CH_ZERO) && (i_symbol <= cpsd_pkg::CH_NINE);

    always_comb begin
        w_cmp_f = w_cmp_b;
        if (w_cmp_b == CMP_EQ && w_pos_b < POS_MAXD) begin
            if (i_symbol > w_ref_char) begin
                w_cmp_f = CMP_GT;
            end else if (i_symbol < w_ref_char) begin
                w_cmp_f = CMP_LT;
            end
        end
    end

    assign w_pos_f = (w_pos_b != POS_SAT) ? w_pos_b + 1'b1 : w_pos_b;
    assign w_bad_f = (w_first ? 1'b0 : r_bad) | ~w_is_digit;
    // times ten as two shifts and an add, wrapping at the value width
    assign w_acc_f = w_is_digit ?
        (w_acc_b << 3) + (w_acc_b << 1) + VALUE_BITS'(i_symbol[3:0]) : w_acc_b;
    assign w_rem_f = (w_first ? w_glen : r_remaining) - VAL_ONE;
    assign w_over  = (w_glen > VAL_MAXD) || (w_glen == VAL_MAXD && w_cmp_f == CMP_GT);

    assign w_acc_ext = EXT_W'(w_acc_f);
    assign w_max_ext = EXT_W'(VAL_MAX);

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_group_len = r_group_len;
        n_acc       = r_acc;
        n_cmp       = r_cmp;
        n_bad       = r_bad;
        n_sign      = r_sign;
        n_pos       = r_pos;
        o_emit      = 1'b0;
        o_result    = '{status: cpsd_pkg::ST_OK, negative: 1'b0, magnitude: '0};

        if (w_first) begin
            n_group_len = w_glen;
            if (i_kind == cpsd_pkg::KIND_EOF) begin
                o_emit          = 1'b1;
                o_result.status = cpsd_pkg::ST_END_FILE;
            end else if (i_kind != cpsd_pkg::KIND_DATA) begin
                o_emit          = 1'b1;
                o_result.status = cpsd_pkg::ST_END_DATA;
            end else if (i_symbol == cpsd_pkg::CH_PLUS || i_symbol == cpsd_pkg::CH_MINUS) begin
                n_sign      = (i_symbol == cpsd_pkg::CH_MINUS);
                n_acc       = '0;
                n_cmp       = CMP_EQ;
                n_bad       = 1'b0;
                n_pos       = '0;
                n_phase     = PH_FINAL;
                n_remaining = w_glen;
            end else if (i_symbol == cpsd_pkg::CH_ZERO) begin
                o_emit          = 1'b1;
                o_result.status = cpsd_pkg::ST_LEAD_ZERO;
            end else if (!(i_symbol inside {[cpsd_pkg::CH_ONE:cpsd_pkg::CH_NINE]})) begin
                o_emit          = 1'b1;
                o_result.status = cpsd_pkg::ST_NONDIGIT;
            end else begin
                n_phase = PH_LENGTH;
            end
        end else if (i_kind != cpsd_pkg::KIND_DATA) begin
            o_emit          = 1'b1;
            o_result.status = cpsd_pkg::ST_END_DATA;
        end

        // byte that feeds a length or final group
        if (!o_emit && (n_phase == PH_LENGTH || n_phase == PH_FINAL) &&
            !(w_first && n_phase == PH_FINAL)) begin
            n_acc       = w_acc_f;
            n_cmp       = w_cmp_f;
            n_bad       = w_bad_f;
            n_pos       = w_pos_f;
            n_remaining = w_rem_f;
            if (w_rem_f == '0) begin
                if (w_over) begin
                    o_emit             = 1'b1;
                    o_result.status    = cpsd_pkg::ST_OVERFLOW;
                    o_result.negative  = (r_phase == PH_FINAL) ? r_sign : 1'b0;
                    o_result.magnitude = w_max_ext[cpsd_pkg::MAG_W-1:0];
                end else if (w_bad_f) begin
                    o_emit          = 1'b1;
                    o_result.status = cpsd_pkg::ST_NONDIGIT;
                end else if (r_phase == PH_FINAL) begin
                    o_emit             = 1'b1;
                    o_result.status    = cpsd_pkg::ST_OK;
                    o_result.negative  = r_sign;
                    o_result.magnitude = w_acc_ext[cpsd_pkg::MAG_W-1:0];
                end else begin
                    n_group_len = (w_acc_f != '0) ? w_acc_f : VAL_ONE;
                    n_phase     = PH_NESTED;
                end
            end
        end

        // a result ends the decode
        if (o_emit) begin
            n_phase     = PH_START;
            n_remaining = '0;
            n_group_len = '0;
            n_acc       = '0;
            n_cmp       = CMP_EQ;
            n_bad       = 1'b0;
            n_sign      = 1'b0;
            n_pos       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_remaining <= '0;
            r_group_len <= '0;
            r_acc       <= '0;
            r_cmp       <= CMP_EQ;
            r_bad       <= 1'b0;
            r_sign      <= 1'b0;
            r_pos       <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_group_len <= n_group_len;
            r_acc       <= n_acc;
            r_cmp       <= n_cmp;
            r_bad       <= n_bad;
            r_sign      <= n_sign;
            r_pos       <= n_pos;
        end
    end

    a_group_open_has_bytes_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LENGTH || r_phase == PH_FINAL) |-> (r_remaining != '0))
        else $error("open group with no bytes left");

    a_nested_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NESTED) |-> (r_group_len != '0))
        else $error("nested group length is zero");

    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit) |=> (r_phase == PH_START && r_acc == '0))
        else $error("decode not restarted after result");

endmodule

### design/count_prefixed_signed_decimal_decoder.sv
// Count-prefixed signed decimal decoder, top level.
//
// i_in carries one beat per stream byte (kind 0) or end marker (kind 1 end of
// data, kind 2 end of file). o_res carries one beat per finished decode: status,
// sign and 32-bit magnitude. Bytes that only advance a decode give no beat.
// start_count (digit count of the first length group) is written through
// i_cfg_we / i_cfg_wdata only while the block is idle, a rule on the user that
// the block does not enforce; it resets to 1 and applies from the next decode.
//
// An input beat is captured in an input register; from there the step logic
// updates the decode state and, if the byte ends a decode, loads the result
// register, which drives o_res. One byte per cycle is sustained: i_in.ready
// stays high while the result register is free or being taken this cycle.
//
// When o_res is stalled with a result waiting, a byte that gives no result
// still goes through; a byte that would end a decode waits in the input
// register and i_in.ready drops. Synchronous reset clears all valid bits and
// puts the decoder at the start of a decode.
// Depends on cpsd_pkg, cpsd_in_if, cpsd_out_if and cpsd_core.
module count_prefixed_signed_decimal_decoder #(
    parameter int VALUE_BITS = cpsd_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = cpsd_pkg::DEF_MAX_DIGITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cpsd_pkg::START_W-1:0] i_cfg_wdata,
    cpsd_in_if.sink                      i_in,
    cpsd_out_if.source                   o_res
);

    logic                          r_in_valid;
    logic [cpsd_pkg::SYMBOL_W-1:0] r_symbol;
    logic [cpsd_pkg::KIND_W-1:0]   r_kind;
    logic                          r_out_valid;
    cpsd_pkg::t_result             r_out;
    logic [cpsd_pkg::START_W-1:0]  r_start_count;

    logic                          w_emit;
    cpsd_pkg::t_result             w_result;
    logic                          w_out_free;
    logic                          w_advance;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign i_in.ready = !r_in_valid || w_advance;

    cpsd_core #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_symbol      (r_symbol),
        .i_kind        (r_kind),
        .i_start_count (r_start_count),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_start_count <= cpsd_pkg::START_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_start_count <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_symbol <= i_in.symbol;
            r_kind   <= i_in.kind;
        end
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out.status;
    assign o_res.negative  = r_out.negative;
    assign o_res.magnitude = r_out.magnitude;

endmodule
